@@ design/go_to_goal_controller_top_macros.svh @@
// Assertion macros shared by the modules of the go-to-goal controller.
`ifndef GO_TO_GOAL_CONTROLLER_TOP_MACROS_SVH
`define GO_TO_GOAL_CONTROLLER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GTG_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define GTG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GTG_ASSERT(label, clk, rst_n, cond)
`define GTG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GTG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/gtg_pkg.sv @@
`timescale 1ns / 1ps
package gtg_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int FRAC_BITS      = 16;
    localparam int ANG_SCALE_BITS = 30;
    localparam int PRESCALE_BITS  = 24;

    // Operand widths through the CORDIC.
    localparam int IN_W   = 34;
    localparam int CW     = 61;
    localparam int MAG_W  = CW - 1;
    localparam int ZW     = 33;
    localparam int ANG_SH = ANG_SCALE_BITS - FRAC_BITS;
    localparam int ANG_W  = ZW - ANG_SH;
    localparam int ERR_W  = ANG_W + 1;

    // Distance scaling.
    localparam int KW     = 30;
    localparam int HI_W   = MAG_W - 32 + KW;
    localparam int SUM_W  = HI_W + 1;
    localparam int DIST_W = SUM_W - 22;
    localparam logic [KW-1:0] INV_CORDIC_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_ANG = 33'sd1686629713;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

    // Register indexes.
    localparam logic [2:0] REG_LINEAR_GAIN  = 3'd0;
    localparam logic [2:0] REG_ANGULAR_GAIN = 3'd1;
    localparam logic [2:0] REG_TOLERANCE    = 3'd2;
    localparam logic [2:0] REG_GOAL_X       = 3'd3;
    localparam logic [2:0] REG_GOAL_Y       = 3'd4;
    localparam logic [2:0] REG_GOAL_VALID   = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_NO_GOAL = 2'd0;
    localparam logic [1:0] STATUS_ARRIVED = 2'd1;
    localparam logic [1:0] STATUS_DRIVING = 2'd2;

    typedef struct packed {
        logic signed [15:0] linear_gain;
        logic signed [15:0] angular_gain;
        logic [30:0]        tolerance;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic               goal_valid;
    } cfg_t;

    typedef struct packed {
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
        logic signed [IN_W-1:0] num;
        logic signed [IN_W-1:0] den;
    } job_t;

    // Arctangent of 2^-i in radians scaled by 2^30, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0:       r = 33'sd843314857;
            1:       r = 33'sd497837829;
            2:       r = 33'sd263043837;
            3:       r = 33'sd133525159;
            4:       r = 33'sd67021687;
            5:       r = 33'sd33543516;
            6:       r = 33'sd16775851;
            7:       r = 33'sd8388437;
            8:       r = 33'sd4194283;
            9:       r = 33'sd2097149;
            10:      r = 33'sd1048576;
            default:
            begin
                if (i < 31)
                    r = 33'sd1 <<< (30 - i);
            end
        endcase
        return r;
    endfunction

endpackage

@@ design/go_to_goal_controller_top.sv @@
`timescale 1ns / 1ps
// Channel   | Direction | Contents
// s_axis    | in        | odometry sample: position x, y and orientation quaternion
// m_axis    | out       | velocity command: forward, turn and status
// apb       | in / out  | gains, tolerance, goal position and goal enable
//
// One sample can be taken per cycle while the queue is not full. A request passes
// through the front stage, the queue, then the CORDIC stages and four arithmetic
// stages of the back part.
// Reset clears only the handshake and queue control and loads the register defaults.
// A stall on m_axis holds the whole back pipeline; the four-entry queue keeps the
// front taking requests until it fills.
module go_to_goal_controller_top
    import gtg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // s_axis_tdata: position_x, position_y, quat_x, quat_y, quat_z, quat_w
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    // m_axis_tdata: linear_velocity, angular_velocity, status, zero padding
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    job_t       q_in;
    job_t       q_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // A register write lands at the access cycle; unused addresses are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_LINEAR_GAIN:  cfg_next.linear_gain  = pwdata[15:0];
                REG_ANGULAR_GAIN: cfg_next.angular_gain = pwdata[15:0];
                REG_TOLERANCE:    cfg_next.tolerance    = pwdata[30:0];
                REG_GOAL_X:       cfg_next.goal_x       = pwdata;
                REG_GOAL_Y:       cfg_next.goal_y       = pwdata;
                REG_GOAL_VALID:   cfg_next.goal_valid   = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_gain  <= 16'sd256;
            cfg_reg.angular_gain <= 16'sd256;
            cfg_reg.tolerance    <= 31'd6554;
            cfg_reg.goal_x       <= '0;
            cfg_reg.goal_y       <= '0;
            cfg_reg.goal_valid   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Reads return the stored value, zero extended to the bus width.
    always_comb
    begin
        case (reg_idx)
            REG_LINEAR_GAIN:  prdata = {16'd0, cfg_reg.linear_gain};
            REG_ANGULAR_GAIN: prdata = {16'd0, cfg_reg.angular_gain};
            REG_TOLERANCE:    prdata = {1'b0, cfg_reg.tolerance};
            REG_GOAL_X:       prdata = cfg_reg.goal_x;
            REG_GOAL_Y:       prdata = cfg_reg.goal_y;
            REG_GOAL_VALID:   prdata = {31'd0, cfg_reg.goal_valid};
            default:          prdata = '0;
        endcase
    end

    // The front part forms the goal offset and the yaw vector of each request.
    gtg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    gtg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back part runs both CORDICs side by side, then scales and saturates.
    gtg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ design/gtg_front.sv @@
`timescale 1ns / 1ps
module gtg_front
    import gtg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  cfg_t         cfg,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_data
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [31:0] pxy_reg;
    logic signed [31:0] pwz_reg;
    logic signed [31:0] pww_reg;
    logic signed [31:0] pxx_reg;
    logic signed [31:0] pyy_reg;
    logic signed [31:0] pzz_reg;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               load;

    assign px = s_axis_tdata[31:0];
    assign py = s_axis_tdata[63:32];
    assign qx = s_axis_tdata[79:64];
    assign qy = s_axis_tdata[95:80];
    assign qz = s_axis_tdata[111:96];
    assign qw = s_axis_tdata[127:112];

    assign q_push        = valid_reg && !q_full;
    assign s_axis_tready = !valid_reg || !q_full;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg  <= {cfg.goal_x[31], cfg.goal_x} - {px[31], px};
            dy_reg  <= {cfg.goal_y[31], cfg.goal_y} - {py[31], py};
            pxy_reg <= qx * qy;
            pwz_reg <= qw * qz;
            pww_reg <= qw * qw;
            pxx_reg <= qx * qx;
            pyy_reg <= qy * qy;
            pzz_reg <= qz * qz;
        end
    end

    // Yaw vector: 2(xy + wz) and w^2 + x^2 - y^2 - z^2.
    always_comb
    begin
        q_data.dx  = IN_W'(dx_reg);
        q_data.dy  = IN_W'(dy_reg);
        q_data.num = (IN_W'(pxy_reg) + IN_W'(pwz_reg)) <<< 1;
        q_data.den = IN_W'(pww_reg) + IN_W'(pxx_reg) - IN_W'(pyy_reg) - IN_W'(pzz_reg);
    end

endmodule

@@ design/gtg_queue.sv @@
`timescale 1ns / 1ps
`include "go_to_goal_controller_top_macros.svh"
module gtg_queue
    import gtg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t pop_data,
    output logic full,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_reg;
    logic [QIDX_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QIDX_W-1:0] wr_next;
    logic [QIDX_W-1:0] rd_next;
    logic [QCNT_W-1:0] cnt_next;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? QIDX_W'((int'(wr_reg) + 1) % QUEUE_DEPTH) : wr_reg;
        rd_next  = pop ? QIDX_W'((int'(rd_reg) + 1) % QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    `GTG_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `GTG_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
    `GTG_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
    `GTG_ASSERT_NEXT(a_push_only_grows, clk, rst_n, push && !pop, !empty)

endmodule

@@ design/gtg_cordic.sv @@
`timescale 1ns / 1ps
module gtg_cordic
    import gtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  x_in,
    input  logic signed [IN_W-1:0]  y_in,
    output logic [MAG_W-1:0]        mag,
    output logic signed [ANG_W-1:0] ang
);

    logic signed [CW-1:0] xs [CORDIC_STAGES+1];
    logic signed [CW-1:0] ys [CORDIC_STAGES+1];
    logic signed [ZW-1:0] zs [CORDIC_STAGES+1];
    logic                 zero_s [CORDIC_STAGES+1];
    logic signed [CW-1:0] xp;
    logic signed [CW-1:0] yp;
    logic signed [ZW-1:0] z_round;

    assign xp = {{(CW-IN_W-PRESCALE_BITS){x_in[IN_W-1]}}, x_in, {PRESCALE_BITS{1'b0}}};
    assign yp = {{(CW-IN_W-PRESCALE_BITS){y_in[IN_W-1]}}, y_in, {PRESCALE_BITS{1'b0}}};

    // Pre-rotation into the right half plane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_s[0] <= (x_in == '0) && (y_in == '0);
            if (xp[CW-1] && !yp[CW-1])
            begin
                xs[0] <= yp;
                ys[0] <= -xp;
                zs[0] <= HALF_PI_ANG;
            end
            else if (xp[CW-1])
            begin
                xs[0] <= -yp;
                ys[0] <= xp;
                zs[0] <= -HALF_PI_ANG;
            end
            else
            begin
                xs[0] <= xp;
                ys[0] <= yp;
                zs[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_s[i+1] <= zero_s[i];
                if (!ys[i][CW-1] && (ys[i] != '0))
                begin
                    xs[i+1] <= xs[i] + (ys[i] >>> i);
                    ys[i+1] <= ys[i] - (xs[i] >>> i);
                    zs[i+1] <= zs[i] + atan_step(i);
                end
                else
                begin
                    xs[i+1] <= xs[i] - (ys[i] >>> i);
                    ys[i+1] <= ys[i] + (xs[i] >>> i);
                    zs[i+1] <= zs[i] - atan_step(i);
                end
            end
        end
    end

    assign z_round = zs[CORDIC_STAGES] + (ZW'(1) <<< (ANG_SH - 1));

    always_comb
    begin
        mag = '0;
        ang = '0;
        if (!zero_s[CORDIC_STAGES])
        begin
            ang = ANG_W'(z_round >>> ANG_SH);
            if (!xs[CORDIC_STAGES][CW-1] && (xs[CORDIC_STAGES] != '0))
                mag = xs[CORDIC_STAGES][MAG_W-1:0];
        end
    end

endmodule

@@ design/gtg_back.sv @@
`timescale 1ns / 1ps
`include "go_to_goal_controller_top_macros.svh"
module gtg_back
    import gtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  job_t        q_data,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata
);

    localparam int DEPTH  = CORDIC_STAGES + 4;
    localparam int LPR_W  = 16 + DIST_W + 1;
    localparam int APR_W  = 16 + ERR_W;
    localparam int ROUND_SH = FRAC_BITS - 8;

    logic [DEPTH-1:0]           vld_reg;
    logic                       adv;
    logic [MAG_W-1:0]           dist_mag;
    logic [MAG_W-1:0]           yaw_mag;
    logic signed [ANG_W-1:0]    bearing;
    logic signed [ANG_W-1:0]    yaw;
    logic [HI_W-1:0]            hi_reg;
    logic [KW-1:0]              lo_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    err2_reg;
    logic [DIST_W-1:0]          dist_reg;
    logic signed [LPR_W-1:0]    lin_prod_reg;
    logic signed [APR_W-1:0]    ang_prod_reg;
    logic                       arrived_reg;
    logic [SUM_W-1:0]           dist_sum;
    logic [63:0]                lo_full;
    logic signed [LPR_W-1:0]    lin_rnd;
    logic signed [APR_W-1:0]    ang_rnd;
    logic [31:0]                lin_sat;
    logic [31:0]                ang_sat;
    logic                       out_valid_reg;
    logic [31:0]                lin_out_reg;
    logic [31:0]                ang_out_reg;
    logic [1:0]                 status_out_reg;
    logic [31:0]                lin_next;
    logic [31:0]                ang_next;
    logic [1:0]                 status_next;

    assign adv   = !out_valid_reg || m_axis_tready;
    assign q_pop = adv && !q_empty;

    gtg_cordic u_bearing (
        .clk  (clk),
        .en   (adv),
        .x_in (q_data.dx),
        .y_in (q_data.dy),
        .mag  (dist_mag),
        .ang  (bearing)
    );

    gtg_cordic u_yaw (
        .clk  (clk),
        .en   (adv),
        .x_in (q_data.den),
        .y_in (q_data.num),
        .mag  (yaw_mag),
        .ang  (yaw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], q_pop};
    end

    assign lo_full  = 64'(dist_mag[31:0]) * 64'(INV_CORDIC_GAIN);
    assign dist_sum = SUM_W'(hi_reg) + SUM_W'(lo_reg) + (SUM_W'(1) << 21);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hi_reg       <= HI_W'(HI_W'(dist_mag[MAG_W-1:32]) * HI_W'(INV_CORDIC_GAIN));
            lo_reg       <= lo_full[32 +: KW];
            err_reg      <= ERR_W'(bearing) - ERR_W'(yaw);
            dist_reg     <= dist_sum[SUM_W-1:22];
            err2_reg     <= err_reg;
            lin_prod_reg <= LPR_W'(cfg.linear_gain) * LPR_W'(signed'({1'b0, dist_reg}));
            ang_prod_reg <= APR_W'(cfg.angular_gain) * APR_W'(err2_reg);
            arrived_reg  <= DIST_W'(dist_reg) < DIST_W'(cfg.tolerance);
        end
    end

    assign lin_rnd = (lin_prod_reg + (LPR_W'(1) <<< 7)) >>> 8;
    assign ang_rnd = (ang_prod_reg + (APR_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;

    always_comb
    begin
        if (lin_rnd[LPR_W-1:31] == '0 || lin_rnd[LPR_W-1:31] == '1)
            lin_sat = lin_rnd[31:0];
        else if (lin_rnd[LPR_W-1])
            lin_sat = 32'h8000_0000;
        else
            lin_sat = 32'h7FFF_FFFF;
        if (ang_rnd[APR_W-1:31] == '0 || ang_rnd[APR_W-1:31] == '1)
            ang_sat = ang_rnd[31:0];
        else if (ang_rnd[APR_W-1])
            ang_sat = 32'h8000_0000;
        else
            ang_sat = 32'h7FFF_FFFF;

        lin_next    = '0;
        ang_next    = '0;
        status_next = STATUS_NO_GOAL;
        if (cfg.goal_valid && arrived_reg)
            status_next = STATUS_ARRIVED;
        else if (cfg.goal_valid)
        begin
            status_next = STATUS_DRIVING;
            lin_next    = lin_sat;
            ang_next    = ang_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin_out_reg    <= lin_next;
            ang_out_reg    <= ang_next;
            status_out_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, status_out_reg, ang_out_reg, lin_out_reg};

    `GTG_ASSERT_IMPL(a_idle_cmds_zero, clk, rst_n,
        out_valid_reg && status_out_reg != STATUS_DRIVING,
        lin_out_reg == '0 && ang_out_reg == '0)
    `GTG_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        out_valid_reg && !m_axis_tready, out_valid_reg && $stable(lin_out_reg))
    `GTG_ASSERT(a_status_code, clk, rst_n,
        !out_valid_reg || status_out_reg != 2'd3)

endmodule

@@ tb/sv/go_to_goal_controller_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the go-to-goal controller. Odometry samples are fed
// in on s_axis from a pending queue, and the expected velocity command for each
// accepted sample is computed by a local steering model. The monitor compares
// every command that leaves on m_axis with the oldest one still outstanding.
module go_to_goal_controller_top_tb;
    import gtg_pkg::*;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } odom_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] ang;
        logic signed [31:0] lin;
    } command_t;

    localparam longint HALF_PI_RAD = 64'sd1686629713;
    localparam longint INV_GAIN    = 64'sd652032874;
    localparam int     IDLE_PCT    = 37;
    localparam int     STALL_LIMIT = 4000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Local copy of the register file, updated as each write completes.
    cfg_t     regs;
    odom_t    pending_odom[$];
    command_t command_expect[$];
    int       failures;
    int       quiet_cycles;
    bit       calm;

    go_to_goal_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Arctangent of 2^-i, radians scaled by 2^30.
    function automatic longint arctan_pow2(input int i);
        longint lut[11];
        lut = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return lut[i];
        if (i < 31)
            return 64'sd1 << (30 - i);
        return 0;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Vectoring rotation: returns the angle in Q.FRAC_BITS radians and the
    // magnitude still carrying the prescale and the rotation gain.
    function automatic longint vector_angle(input longint x0, input longint y0,
                                            output longint mag);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint t;
        x = x0;
        y = y0;
        z = 0;
        mag = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x <<< PRESCALE_BITS;
        y = y <<< PRESCALE_BITS;
        // Fold the left half-plane onto the right one first.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_RAD;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_RAD;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_pow2(i);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_pow2(i);
            end
            x = nx;
            y = ny;
        end
        mag = (x > 0) ? x : 0;
        return round_shift(z, ANG_SCALE_BITS - FRAC_BITS);
    endfunction

    function automatic command_t steer(input odom_t o);
        command_t c;
        longint   raw;
        longint   unused_mag;
        longint   bearing;
        longint   heading;
        longint   distance;
        longint   num;
        longint   den;
        longint   qx;
        longint   qy;
        longint   qz;
        longint   qw;
        c = '0;
        qx = longint'(o.qx);
        qy = longint'(o.qy);
        qz = longint'(o.qz);
        qw = longint'(o.qw);
        if (!regs.goal_valid)
        begin
            c.status = STATUS_NO_GOAL;
            return c;
        end
        bearing = vector_angle(longint'(regs.goal_x) - longint'(o.px),
                               longint'(regs.goal_y) - longint'(o.py), raw);
        // Gain compensation: high word times 1/K plus the top of the low word.
        distance = ((raw >>> 32) * INV_GAIN) + (((raw & 64'hFFFF_FFFF) * INV_GAIN) >>> 32);
        distance = (distance + (64'sd1 <<< 21)) >>> 22;
        if (distance < longint'({1'b0, regs.tolerance}))
        begin
            c.status = STATUS_ARRIVED;
            return c;
        end
        num = 2 * (qx * qy + qw * qz);
        den = qw * qw + qx * qx - qy * qy - qz * qz;
        heading = vector_angle(den, num, unused_mag);
        c.status = STATUS_DRIVING;
        c.lin = 32'(clip32(round_shift(longint'(regs.linear_gain) * distance, 8)));
        c.ang = 32'(clip32(round_shift(longint'(regs.angular_gain) * (bearing - heading),
                                       FRAC_BITS - 8)));
        return c;
    endfunction

    // Driver: presents the next pending sample, idling at random unless calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                command_expect.push_back(steer(odom_t'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_odom.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tdata  <= pending_odom.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison of every command.
    always @(posedge clk or negedge rst_n)
    begin
        command_t got;
        command_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = command_t'(m_axis_tdata[65:0]);
                if (command_expect.size() == 0)
                begin
                    $display("%0t: unexpected command, expected none, actual %h",
                             $realtime, m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want = command_expect.pop_front();
                    if (got.lin !== want.lin)
                    begin
                        $display("%0t: linear_velocity expected %0d actual %0d",
                                 $realtime, want.lin, got.lin);
                        failures++;
                    end
                    if (got.ang !== want.ang)
                    begin
                        $display("%0t: angular_velocity expected %0d actual %0d",
                                 $realtime, want.ang, got.ang);
                        failures++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LINEAR_GAIN:  regs.linear_gain  = value[15:0];
            REG_ANGULAR_GAIN: regs.angular_gain = value[15:0];
            REG_TOLERANCE:    regs.tolerance    = value[30:0];
            REG_GOAL_X:       regs.goal_x       = value;
            REG_GOAL_Y:       regs.goal_y       = value;
            REG_GOAL_VALID:   regs.goal_valid   = value[0];
            default:;
        endcase
    endtask

    task automatic load_setup(input logic [15:0] lg, input logic [15:0] ag,
                              input logic [30:0] tol, input logic [31:0] gx,
                              input logic [31:0] gy, input logic gv);
        reg_write(REG_LINEAR_GAIN, {16'd0, lg});
        reg_write(REG_ANGULAR_GAIN, {16'd0, ag});
        reg_write(REG_TOLERANCE, {1'b0, tol});
        reg_write(REG_GOAL_X, gx);
        reg_write(REG_GOAL_Y, gy);
        reg_write(REG_GOAL_VALID, {31'd0, gv});
    endtask

    // Blocks until every queued request has gone in and every command is back.
    task automatic drain();
        while (pending_odom.size() != 0 || s_axis_tvalid || command_expect.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_quat();
        return 16'($urandom_range(32768)) - 16'd16384;
    endfunction

    function automatic logic [31:0] near(input logic signed [31:0] centre, input int spread);
        longint v;
        v = longint'(centre) + longint'($urandom_range(2 * spread)) - spread;
        return 32'(clip32(v));
    endfunction

    function automatic odom_t random_odom();
        odom_t o;
        int    pick;
        int    reach;
        pick = $urandom_range(99);
        reach = (regs.tolerance > 31'd1000000) ? 32'h0100_0000 : int'(regs.tolerance) * 3 + 4;
        if (pick < 55)
        begin
            o.px = near(regs.goal_x, 1 << $urandom_range(24, 4));
            o.py = near(regs.goal_y, 1 << $urandom_range(24, 4));
        end
        else if (pick < 75)
        begin
            o.px = $urandom;
            o.py = $urandom;
        end
        else if (pick < 90)
        begin
            o.px = near(regs.goal_x, reach);
            o.py = near(regs.goal_y, reach);
        end
        else
        begin
            o.px = regs.goal_x;
            o.py = regs.goal_y;
        end
        o.qx = rand_quat();
        o.qy = rand_quat();
        o.qz = rand_quat();
        o.qw = rand_quat();
        if ($urandom_range(19) == 0)
            o = {64'd0, o.py, o.px};
        return o;
    endfunction

    function automatic odom_t make_odom(input logic [31:0] px, input logic [31:0] py,
                                        input logic [15:0] qx, input logic [15:0] qy,
                                        input logic [15:0] qz, input logic [15:0] qw);
        return {qw, qz, qy, qx, py, px};
    endfunction

    initial
    begin
        failures      = 0;
        quiet_cycles  = 0;
        calm          = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        regs = '{linear_gain: 16'sd256, angular_gain: 16'sd256, tolerance: 31'd6554,
                 goal_x: 32'sd0, goal_y: 32'sd0, goal_valid: 1'b0};
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // With no goal written every command must be zero with a no-goal status.
        pending_odom.push_back(make_odom(32'h7FFF_FFFF, 32'h8000_0000, 16'd16384,
                                         16'hC000, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'd65536, 32'd6554, 16'd0, 16'd0, 16'd0, 16'd16384));
        drain();

        // Goal at the origin with zero tolerance: sitting exactly on the goal still
        // drives, with a zero forward command and a bearing of zero.
        load_setup(16'd256, 16'd256, 31'd0, 32'd0, 32'd0, 1'b1);
        pending_odom.push_back(make_odom(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384));
        pending_odom.push_back(make_odom(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd16384, 16'd16384,
                                         16'd16384, 16'd16384));
        pending_odom.push_back(make_odom(32'h8000_0000, 32'h8000_0000, 16'hC000, 16'hC000,
                                         16'hC000, 16'hC000));
        pending_odom.push_back(make_odom(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0,
                                         16'd16384, 16'd0));
        pending_odom.push_back(make_odom(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0,
                                         16'hC000, 16'd0));
        pending_odom.push_back(make_odom(32'h0001_0000, 32'd0, 16'd1, 16'd2, 16'd3, 16'd4));
        pending_odom.push_back(make_odom(32'd0, 32'hFFFF_0000, 16'd16384, 16'd0, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'hFFFF_0000, 32'd0, 16'd0, 16'd16384, 16'd0, 16'd0));
        drain();

        // Extreme gains with the goal in a far corner, where a sample just beside the goal
        // reports arrival, then a large tolerance with samples in the far corners.
        load_setup(16'h7FFF, 16'h8000, 31'd6554, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        pending_odom.push_back(make_odom(32'h8000_0000, 32'h7FFF_FFFF, 16'd100, 16'd200,
                                         16'hC000, 16'd16384));
        pending_odom.push_back(make_odom(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'h7FFF_F000, 32'h8000_1000, 16'd0, 16'd0, 16'd0, 16'd0));
        drain();
        load_setup(16'h8000, 16'h7FFF, 31'h7FFF_FFFF, 32'd0, 32'd0, 1'b1);
        pending_odom.push_back(make_odom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_odom.push_back(make_odom(32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0));
        drain();

        // Random phases, each with a fresh register setting. The fifth phase
        // runs with no idling on either side.
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: load_setup(16'd256, 16'd256, 31'd6554, 32'd0, 32'd0, 1'b1);
                1: load_setup(16'h8000, 16'h8000, 31'd0, $urandom, $urandom, 1'b1);
                2: load_setup(16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF, $urandom, $urandom, 1'b1);
                3: load_setup(16'($urandom), 16'($urandom), 31'($urandom_range(200000)),
                              $urandom, $urandom, 1'b0);
                default: load_setup(16'($urandom), 16'($urandom),
                                    31'($urandom_range(500000)), $urandom, $urandom, 1'b1);
            endcase
            calm = (phase == 4);
            for (int n = 0; n < 150; n++)
                pending_odom.push_back(random_odom());
            drain();
        end

        repeat (CORDIC_STAGES + 30) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
